// ----- src/aalr_pkg.sv -----
// aalr_pkg: types and constants shared by the line rasteriser modules
// depends on nothing

package aalr_pkg;

	typedef enum logic [2:0] {
		MODE_HORIZ = 3'd0,
		MODE_VERT  = 3'd1,
		MODE_DIAG  = 3'd2,
		MODE_YMAJ  = 3'd3,
		MODE_XMAJ  = 3'd4
	} line_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_STEP,
		ST_OUT0,
		ST_OUT1
	} state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV,
		OP_STEP
	} dp_op_t;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_STEP = 1'b1;
	localparam logic [1:0] CFG_BASE_COLOR = 2'd0;
	localparam logic [1:0] CFG_INT_BITS   = 2'd1;

	typedef struct packed {
		dp_op_t op;
		logic   sel_second;
	} dp_cmd_t;

	typedef struct packed {
		logic weighted;
		logic div_done;
		logic busy;
		logic two_px;
	} dp_stat_t;

endpackage

// ----- src/aalr_datapath.sv -----
// aalr_datapath: endpoint ordering, error-step divider, stepping and pixel build
// depends on aalr_pkg

module aalr_datapath #(
	parameter int COORD_BITS    = 10,
	parameter int FRACTION_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  aalr_pkg::dp_cmd_t       cmd,
	output aalr_pkg::dp_stat_t      stat,
	input  logic [COORD_BITS-1:0]   x_start,
	input  logic [COORD_BITS-1:0]   y_start,
	input  logic [COORD_BITS-1:0]   x_end,
	input  logic [COORD_BITS-1:0]   y_end,
	input  logic [7:0]              base_color,
	input  logic [3:0]              intensity_bits,
	output logic [COORD_BITS-1:0]   pixel_x,
	output logic [COORD_BITS-1:0]   pixel_y,
	output logic [7:0]              pixel_color,
	output logic                    last_pixel
);

	localparam int CB = COORD_BITS;
	localparam int FB = FRACTION_BITS;
	localparam int DW = CB + FB;
	localparam int CW = $clog2(DW + 1);

	logic [FB-1:0] acc_q, estep_q;
	logic [CB-1:0] cx_q, cy_q, fx_q, fy_q;
	logic [CB:0]   steps_q;
	logic          left_q, busy_q;
	aalr_pkg::line_mode_t mode_q;

	// restoring divider state
	logic [DW-1:0] quo_q;
	logic [CB:0]   rem_q;
	logic [CB-1:0] dvs_q;
	logic [CW-1:0] cnt_q;

	// pixel pair built by a step
	logic [CB-1:0] p0x_q, p0y_q, p1x_q, p1y_q;
	logic [7:0]    p0c_q, p1c_q;
	logic          last_q, two_q;

	// load ordering
	logic          swp;
	logic [CB-1:0] x0, y0, x1, y1, dx, dy;
	logic          lft;
	assign swp = y_start > y_end;
	assign x0  = swp ? x_end : x_start;
	assign y0  = swp ? y_end : y_start;
	assign x1  = swp ? x_start : x_end;
	assign y1  = swp ? y_start : y_end;
	assign lft = x1 < x0;
	assign dx  = lft ? x0 - x1 : x1 - x0;
	assign dy  = y1 - y0;

	// step arithmetic
	logic [FB:0]   acc_sum;
	logic [FB-1:0] acc_n;
	logic          wrap;
	logic [3:0]    ib;
	logic [7:0]    w, wc, lvl_mask;
	logic [CB-1:0] nx, ny, sx;
	logic [FB+7:0] acc_ext;

	function automatic logic [CB-1:0] stepx(input logic [CB-1:0] v, input logic l);
		stepx = l ? v - 1'b1 : v + 1'b1;
	endfunction

	assign acc_sum  = {1'b0, acc_q} + {1'b0, estep_q};
	assign acc_n    = acc_sum[FB-1:0];
	assign wrap     = acc_n <= acc_q;
	assign ib       = (intensity_bits == 4'd0) ? 4'd1 :
		(intensity_bits > 4'd8) ? 4'd8 : intensity_bits;
	assign acc_ext  = {acc_n, 8'd0};
	assign w        = 8'(acc_ext >> (FB + 8 - int'(ib)));
	assign lvl_mask = 8'((9'd1 << ib) - 9'd1);
	assign wc       = w ^ lvl_mask;

	// divider trial subtract
	logic [CB+1:0] trial;
	logic [CB:0]   rsh;
	assign rsh   = {rem_q[CB-1:0], quo_q[DW-1]};
	assign trial = {1'b0, rsh} - {2'b0, dvs_q};

	always_comb begin
		nx = cx_q;
		ny = cy_q;
		sx = cx_q;
		case (mode_q)
			aalr_pkg::MODE_YMAJ: begin
				nx = wrap ? stepx(cx_q, left_q) : cx_q;
				ny = cy_q + 1'b1;
			end
			aalr_pkg::MODE_XMAJ: begin
				ny = wrap ? cy_q + 1'b1 : cy_q;
				nx = stepx(cx_q, left_q);
			end
			aalr_pkg::MODE_HORIZ: nx = stepx(cx_q, left_q);
			aalr_pkg::MODE_VERT:  ny = cy_q + 1'b1;
			aalr_pkg::MODE_DIAG: begin
				nx = stepx(cx_q, left_q);
				ny = cy_q + 1'b1;
			end
			default: ;
		endcase
		sx = stepx(nx, left_q);
	end

	logic weighted;
	assign weighted = (mode_q == aalr_pkg::MODE_YMAJ) || (mode_q == aalr_pkg::MODE_XMAJ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			estep_q <= '0;
			cx_q    <= '0;
			cy_q    <= '0;
			fx_q    <= '0;
			fy_q    <= '0;
			steps_q <= '0;
			left_q  <= 1'b0;
			mode_q  <= aalr_pkg::MODE_HORIZ;
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			two_q   <= 1'b0;
			quo_q   <= '0;
			rem_q   <= '0;
			dvs_q   <= '0;
			p0x_q   <= '0;
			p0y_q   <= '0;
			p1x_q   <= '0;
			p1y_q   <= '0;
			p0c_q   <= '0;
			p1c_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			case (cmd.op)
				aalr_pkg::OP_LOAD: begin
					cx_q    <= x0;
					cy_q    <= y0;
					fx_q    <= x1;
					fy_q    <= y1;
					acc_q   <= '0;
					estep_q <= '0;
					left_q  <= lft;
					two_q   <= 1'b0;
					p0x_q   <= x0;
					p0y_q   <= y0;
					p0c_q   <= base_color;
					cnt_q   <= CW'(DW);
					rem_q   <= '0;
					if (dy == '0) begin
						mode_q  <= aalr_pkg::MODE_HORIZ;
						steps_q <= {1'b0, dx};
						busy_q  <= dx != '0;
						last_q  <= dx == '0;
					end else if (dx == '0) begin
						mode_q  <= aalr_pkg::MODE_VERT;
						steps_q <= {1'b0, dy};
						busy_q  <= 1'b1;
						last_q  <= 1'b0;
					end else if (dx == dy) begin
						mode_q  <= aalr_pkg::MODE_DIAG;
						steps_q <= {1'b0, dy};
						busy_q  <= 1'b1;
						last_q  <= 1'b0;
					end else if (dy > dx) begin
						mode_q  <= aalr_pkg::MODE_YMAJ;
						steps_q <= {1'b0, dy - 1'b1};
						quo_q   <= {dx, {FB{1'b0}}};
						dvs_q   <= dy;
						busy_q  <= 1'b1;
						last_q  <= 1'b0;
					end else begin
						mode_q  <= aalr_pkg::MODE_XMAJ;
						steps_q <= {1'b0, dx - 1'b1};
						quo_q   <= {dy, {FB{1'b0}}};
						dvs_q   <= dx;
						busy_q  <= 1'b1;
						last_q  <= 1'b0;
					end
				end
				aalr_pkg::OP_DIV: begin
					// one quotient bit a cycle
					if (trial[CB+1]) begin
						rem_q <= rsh;
						quo_q <= {quo_q[DW-2:0], 1'b0};
					end else begin
						rem_q <= trial[CB:0];
						quo_q <= {quo_q[DW-2:0], 1'b1};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						estep_q <= trial[CB+1] ? {quo_q[FB-2:0], 1'b0}
							: {quo_q[FB-2:0], 1'b1};
					end
				end
				aalr_pkg::OP_STEP: begin
					if (weighted && steps_q == '0) begin
						busy_q <= 1'b0;
						two_q  <= 1'b0;
						p0x_q  <= fx_q;
						p0y_q  <= fy_q;
						p0c_q  <= base_color;
						last_q <= 1'b1;
					end else if (weighted) begin
						steps_q <= steps_q - 1'b1;
						acc_q   <= acc_n;
						cx_q    <= nx;
						cy_q    <= ny;
						two_q   <= 1'b1;
						last_q  <= 1'b0;
						p0x_q   <= nx;
						p0y_q   <= ny;
						p0c_q   <= base_color + w;
						p1c_q   <= base_color + wc;
						if (mode_q == aalr_pkg::MODE_YMAJ) begin
							p1x_q <= sx;
							p1y_q <= ny;
						end else begin
							p1x_q <= nx;
							p1y_q <= ny + 1'b1;
						end
					end else begin
						cx_q   <= nx;
						cy_q   <= ny;
						two_q  <= 1'b0;
						p0x_q  <= nx;
						p0y_q  <= ny;
						p0c_q  <= base_color;
						if (steps_q <= (CB + 1)'(1)) begin
							steps_q <= '0;
							last_q  <= 1'b1;
							busy_q  <= 1'b0;
						end else begin
							steps_q <= steps_q - 1'b1;
							last_q  <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign stat.weighted = weighted;
	assign stat.div_done = cnt_q == '0;
	assign stat.busy     = busy_q;
	assign stat.two_px   = two_q;

	assign pixel_x     = cmd.sel_second ? p1x_q : p0x_q;
	assign pixel_y     = cmd.sel_second ? p1y_q : p0y_q;
	assign pixel_color = cmd.sel_second ? p1c_q : p0c_q;
	assign last_pixel  = cmd.sel_second ? 1'b0 : last_q;

endmodule

// ----- src/aalr_ctrl.sv -----
// aalr_ctrl: sequencer for load, divide, step and pixel output
// depends on aalr_pkg

module aalr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	output logic                out_valid,
	input  logic                out_ready,
	input  aalr_pkg::dp_stat_t  stat,
	output aalr_pkg::dp_cmd_t   cmd
);

	aalr_pkg::state_t state_q, state_n;
	logic acc;

	assign acc = in_valid && in_ready;

	always_comb begin
		state_n = state_q;
		case (state_q)
			aalr_pkg::ST_IDLE: begin
				if (acc && req_type == aalr_pkg::REQ_LOAD) state_n = aalr_pkg::ST_DIV;
				else if (acc && stat.busy) state_n = aalr_pkg::ST_STEP;
			end
			aalr_pkg::ST_DIV:
				if (!stat.weighted || stat.div_done) state_n = aalr_pkg::ST_OUT0;
			aalr_pkg::ST_STEP: state_n = aalr_pkg::ST_OUT0;
			aalr_pkg::ST_OUT0:
				if (out_ready) state_n = stat.two_px ? aalr_pkg::ST_OUT1 : aalr_pkg::ST_IDLE;
			aalr_pkg::ST_OUT1:
				if (out_ready) state_n = aalr_pkg::ST_IDLE;
			default: state_n = aalr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = state_q == aalr_pkg::ST_IDLE;
		out_valid      = 1'b0;
		cmd.op         = aalr_pkg::OP_NONE;
		cmd.sel_second = 1'b0;
		case (state_q)
			aalr_pkg::ST_IDLE:
				if (acc && req_type == aalr_pkg::REQ_LOAD) cmd.op = aalr_pkg::OP_LOAD;
			aalr_pkg::ST_DIV:
				if (stat.weighted && !stat.div_done) cmd.op = aalr_pkg::OP_DIV;
			aalr_pkg::ST_STEP: cmd.op = aalr_pkg::OP_STEP;
			aalr_pkg::ST_OUT0: out_valid = 1'b1;
			aalr_pkg::ST_OUT1: begin
				out_valid      = 1'b1;
				cmd.sel_second = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= aalr_pkg::ST_IDLE;
		else state_q <= state_n;
	end

endmodule

// ----- src/antialiased_line_rasterizer_core.sv -----
// antialiased_line_rasterizer_core: top level, config registers and wiring
// depends on aalr_pkg, aalr_ctrl, aalr_datapath
//
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   req_type, x_start, y_start, x_end, y_end
// out      output     out_valid / out_ready pixel_x, pixel_y, pixel_color, last_pixel
// cfg      input      cfg_we                cfg_index, cfg_data
//
// a step goes through ST_STEP, ST_OUT0 and, for a second pixel, ST_OUT1;
// a weighted load has the bit-serial divider form COORD_BITS + FRACTION_BITS bits
// one item in flight at a time; in_ready stays low until all its pixels go
// reset clears all line state and sets base_color 0, intensity_bits 4

module antialiased_line_rasterizer_core #(
	parameter int COORD_BITS    = 10,
	parameter int FRACTION_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  req_type,
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COORD_BITS-1:0] x_end,
	input  logic [COORD_BITS-1:0] y_end,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic [7:0]            pixel_color,
	output logic                  last_pixel,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [7:0]            cfg_data
);

	logic [7:0] base_q;
	logic [3:0] ibits_q;
	aalr_pkg::dp_cmd_t  cmd;
	aalr_pkg::dp_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= 8'd0;
			ibits_q <= 4'd4;
		end else if (cfg_we) begin
			if (cfg_index == aalr_pkg::CFG_BASE_COLOR) base_q <= cfg_data;
			else if (cfg_index == aalr_pkg::CFG_INT_BITS) ibits_q <= cfg_data[3:0];
		end
	end

	aalr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	aalr_datapath #(
		.COORD_BITS    (COORD_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.x_start        (x_start),
		.y_start        (y_start),
		.x_end          (x_end),
		.y_end          (y_end),
		.base_color     (base_q),
		.intensity_bits (ibits_q),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.pixel_color    (pixel_color),
		.last_pixel     (last_pixel)
	);

endmodule

// ----- dv/aalr_checker.sv -----
// aalr_checker: watches the item and pixel channels, predicts pixels and compares them
// depends on aalr_pkg; configuration is mirrored from the write port

`timescale 1ns / 100ps

module aalr_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic       req_type,
	input  logic [9:0] x_start,
	input  logic [9:0] y_start,
	input  logic [9:0] x_end,
	input  logic [9:0] y_end,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [9:0] pixel_x,
	input  logic [9:0] pixel_y,
	input  logic [7:0] pixel_color,
	input  logic       last_pixel,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output int         fail_count,
	output int         pending,
	output int         pixels_seen,
	output int         lines_done
);

	typedef struct packed {
		logic [9:0] x;
		logic [9:0] y;
		logic [7:0] c;
		logic       last;
	} pixel_t;

	pixel_t pixel_q[$];

	logic [7:0]  m_base;
	logic [3:0]  m_ibits;
	logic [15:0] m_acc, m_inc;
	logic [9:0]  m_cx, m_cy, m_fx, m_fy;
	logic [10:0] m_left;
	logic        m_left_dir, m_busy;
	aalr_pkg::line_mode_t m_mode;

	assign pending = pixel_q.size();

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
		fail_count++;
	endtask

	function automatic logic [9:0] xstep(input logic [9:0] x);
		return m_left_dir ? x - 10'd1 : x + 10'd1;
	endfunction

	task automatic push_pixel(input logic [9:0] x, input logic [9:0] y,
			input logic [7:0] c, input logic last);
		pixel_t p;
		p.x = x; p.y = y; p.c = c; p.last = last;
		pixel_q.push_back(p);
	endtask

	task automatic predict_load(input logic [9:0] xa, input logic [9:0] ya,
			input logic [9:0] xb, input logic [9:0] yb);
		logic [9:0] dx, dy, t;
		if (ya > yb) begin
			t = ya; ya = yb; yb = t;
			t = xa; xa = xb; xb = t;
		end
		m_cx = xa; m_cy = ya; m_fx = xb; m_fy = yb;
		m_acc = '0; m_inc = '0;
		m_left_dir = xb < xa;
		dx = m_left_dir ? xa - xb : xb - xa;
		dy = yb - ya;
		if (dy == 0) begin
			m_mode = aalr_pkg::MODE_HORIZ; m_left = dx;
		end else if (dx == 0) begin
			m_mode = aalr_pkg::MODE_VERT; m_left = dy;
		end else if (dx == dy) begin
			m_mode = aalr_pkg::MODE_DIAG; m_left = dy;
		end else if (dy > dx) begin
			m_mode = aalr_pkg::MODE_YMAJ; m_left = dy - 1;
			m_inc = 16'(({16'd0, dx} << 16) / dy);
		end else begin
			m_mode = aalr_pkg::MODE_XMAJ; m_left = dx - 1;
			m_inc = 16'(({16'd0, dy} << 16) / dx);
		end
		m_busy = !(m_mode == aalr_pkg::MODE_HORIZ && m_left == 0);
		push_pixel(xa, ya, m_base, !m_busy);
	endtask

	task automatic predict_step();
		logic [15:0] prev;
		int ib;
		logic [7:0] w, wc;
		if (!m_busy)
			return;
		if (m_mode == aalr_pkg::MODE_YMAJ || m_mode == aalr_pkg::MODE_XMAJ) begin
			if (m_left == 0) begin
				m_busy = 0;
				push_pixel(m_fx, m_fy, m_base, 1'b1);
				return;
			end
			m_left--;
			prev = m_acc;
			m_acc = m_acc + m_inc;
			ib = m_ibits < 1 ? 1 : (m_ibits > 8 ? 8 : m_ibits);
			w = 8'(m_acc >> (16 - ib));
			wc = w ^ 8'((1 << ib) - 1);
			if (m_mode == aalr_pkg::MODE_YMAJ) begin
				if (m_acc <= prev) m_cx = xstep(m_cx);
				m_cy++;
				push_pixel(m_cx, m_cy, m_base + w, 1'b0);
				push_pixel(xstep(m_cx), m_cy, m_base + wc, 1'b0);
			end else begin
				if (m_acc <= prev) m_cy++;
				m_cx = xstep(m_cx);
				push_pixel(m_cx, m_cy, m_base + w, 1'b0);
				push_pixel(m_cx, m_cy + 10'd1, m_base + wc, 1'b0);
			end
			return;
		end
		if (m_mode == aalr_pkg::MODE_HORIZ || m_mode == aalr_pkg::MODE_DIAG)
			m_cx = xstep(m_cx);
		if (m_mode == aalr_pkg::MODE_VERT || m_mode == aalr_pkg::MODE_DIAG) m_cy++;
		if (m_left > 0) m_left--;
		if (m_left == 0) m_busy = 0;
		push_pixel(m_cx, m_cy, m_base, m_left == 0);
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t p;
		if (!arst_n) begin
			pixel_q.delete();
			m_base = 8'd0; m_ibits = 4'd4;
			m_acc = '0; m_inc = '0; m_cx = '0; m_cy = '0; m_fx = '0; m_fy = '0;
			m_left = '0; m_left_dir = 0; m_mode = aalr_pkg::MODE_HORIZ; m_busy = 0;
			fail_count = 0; pixels_seen = 0; lines_done = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == aalr_pkg::CFG_BASE_COLOR) m_base = cfg_data;
				else if (cfg_index == aalr_pkg::CFG_INT_BITS) m_ibits = cfg_data[3:0];
			end
			if (out_valid && out_ready) begin
				pixels_seen++;
				if (last_pixel) lines_done++;
				if (pixel_q.size() == 0) begin
					report("unexpected pixel x", 32'(pixel_x), 32'hffff_ffff);
				end else begin
					p = pixel_q.pop_front();
					if (pixel_x !== p.x) report("pixel_x", 32'(pixel_x), 32'(p.x));
					if (pixel_y !== p.y) report("pixel_y", 32'(pixel_y), 32'(p.y));
					if (pixel_color !== p.c)
						report("pixel_color", 32'(pixel_color), 32'(p.c));
					if (last_pixel !== p.last)
						report("last_pixel", 32'(last_pixel), 32'(p.last));
				end
			end
			if (in_valid && in_ready) begin
				if (req_type == aalr_pkg::REQ_LOAD)
					predict_load(x_start, y_start, x_end, y_end);
				else predict_step();
			end
		end
	end

endmodule

// ----- dv/testbench.sv -----
// testbench: drives random and directed line items and configuration into the rasteriser
// depends on aalr_pkg, antialiased_line_rasterizer_core, aalr_checker

`timescale 1ns / 100ps

module testbench;

	logic       clk = 0, arst_n = 0;
	logic       in_valid = 0, in_ready, req_type = aalr_pkg::REQ_LOAD;
	logic [9:0] x_start = '0, y_start = '0, x_end = '0, y_end = '0;
	logic       out_valid, out_ready = 0, last_pixel;
	logic [9:0] pixel_x, pixel_y;
	logic [7:0] pixel_color;
	logic       cfg_we = 0;
	logic [1:0] cfg_index = aalr_pkg::CFG_BASE_COLOR;
	logic [7:0] cfg_data = '0;
	int         fail_count, pending, pixels_seen, lines_done;
	int         idle_pct = 29, hold_cycles = 0, items_sent = 0;

	always #5 clk = ~clk;

	antialiased_line_rasterizer_core u_dut (.*);

	aalr_checker u_chk (.*);

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 0;
		end else begin
			out_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// in_valid stays up after an accept unless the next item idles first
	task automatic send_item(input logic rt, input logic [9:0] xa, input logic [9:0] ya,
			input logic [9:0] xb, input logic [9:0] yb);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		in_valid <= 1; req_type <= rt;
		x_start <= xa; y_start <= ya; x_end <= xb; y_end <= yb;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0 || !in_ready) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [1:0] idx, input logic [7:0] val);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic run_line(input logic [9:0] xa, input logic [9:0] ya,
			input logic [9:0] xb, input logic [9:0] yb, input int steps);
		send_item(aalr_pkg::REQ_LOAD, xa, ya, xb, yb);
		repeat (steps) send_item(aalr_pkg::REQ_STEP, 10'($urandom), 10'($urandom),
			10'($urandom), 10'($urandom));
	endtask

	// short lines mostly; a line of length n needs about n steps
	task automatic random_line();
		logic [9:0] xa, ya, xb, yb;
		int len;
		xa = 10'($urandom); ya = 10'($urandom);
		len = ($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(6);
		xb = xa + 10'($urandom_range(2 * len) - len);
		yb = ya + 10'($urandom_range(2 * len) - len);
		if ($urandom_range(9) == 0) begin
			xb = 10'($urandom); yb = 10'($urandom);
		end
		// mostly complete lines, some cut short or overrun
		case ($urandom_range(9))
			0: run_line(xa, ya, xb, yb, $urandom_range(3));
			1: run_line(xa, ya, xb, yb, len + 4);
			default: run_line(xa, ya, xb, yb, len + 2);
		endcase
		if (xb - xa > 10 || yb - ya > 10) begin
			if (!($urandom_range(3) == 0)) run_line(xa, ya, xa, ya, 0);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: idle step, single point, each mode, extremes, restart
		send_item(aalr_pkg::REQ_STEP, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff);
		run_line(10'd5, 10'd5, 10'd5, 10'd5, 1);
		run_line(10'd0, 10'd0, 10'd3, 10'd0, 3);
		run_line(10'd3, 10'd4, 10'd3, 10'd0, 4);
		run_line(10'd3, 10'd0, 10'd0, 10'd3, 3);
		run_line(10'd0, 10'd0, 10'd2, 10'd5, 5);
		run_line(10'd7, 10'd9, 10'd0, 10'd6, 7);
		run_line(10'h3ff, 10'h3ff, 10'h3fd, 10'h000, 2);
		run_line(10'd1, 10'd1, 10'd4, 10'd2, 1);
		wait_drained();

		write_cfg(aalr_pkg::CFG_BASE_COLOR, 8'hff);
		write_cfg(aalr_pkg::CFG_INT_BITS, 8'd8);
		run_line(10'd0, 10'd0, 10'd9, 10'd4, 10);
		run_line(10'h3ff, 10'd0, 10'd0, 10'd2, 3);
		wait_drained();
		write_cfg(aalr_pkg::CFG_INT_BITS, 8'd1);
		write_cfg(2'd3, 8'h55);
		run_line(10'd0, 10'd0, 10'd3, 10'd8, 9);
		wait_drained();
		write_cfg(aalr_pkg::CFG_INT_BITS, 8'd0);
		run_line(10'd2, 10'd0, 10'd0, 10'd7, 8);
		wait_drained();
		write_cfg(aalr_pkg::CFG_INT_BITS, 8'd15);
		run_line(10'd0, 10'd0, 10'd7, 10'd3, 8);
		wait_drained();

		// long receiver hold-off while items keep coming
		hold_cycles = 300;
		run_line(10'd100, 10'd100, 10'd120, 10'd113, 12);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			write_cfg(aalr_pkg::CFG_BASE_COLOR, 8'($urandom));
			write_cfg(aalr_pkg::CFG_INT_BITS, 8'($urandom_range(15)));
			idle_pct = (ph == 2) ? 0 : 29;
			while (items_sent < 180 * (ph + 1) + 60) random_line();
			wait_drained();
		end
		write_cfg(aalr_pkg::CFG_BASE_COLOR, 8'd0);
		write_cfg(aalr_pkg::CFG_INT_BITS, 8'd4);
		while (items_sent < 880) random_line();

		wait_drained();
		$display("sent %0d items, checked %0d pixels over %0d finished lines",
			items_sent, pixels_seen, lines_done);
		$display("covered all line modes, idle steps, restarts and several palettes");
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout");
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
